>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file taq_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check an implication on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// check an implication in the next cycle
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

>>> rtl/core/taq_pkg.sv
// Types and constants of the timed action queue.
// No dependencies.
`timescale 1ns / 1ps
package taq_pkg;
  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam int MAX_RESULTS = 16;
  // ceil(2^40 / 28125); 3600000 = 28125 << 7
  localparam logic [25:0] HOUR_RECIP = 26'd39093747;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0, OP_POP_DUE = 3'd1, OP_POP_NEAR = 3'd2,
    OP_DELETE = 3'd3, OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0, ST_FULL = 3'd1, ST_POPPED = 3'd2, ST_NONE = 3'd3,
    ST_DELETED = 3'd4, ST_NOT_FOUND = 3'd5, ST_CLEARED = 3'd6
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] hour;
    logic [31:0] sec_ms;
    logic [7:0]  action_code;
    logic [15:0] proxy;
    logic [15:0] owner_id;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [7:0]  code_out;
    logic [15:0] proxy_out;
    logic [15:0] owner_out;
    logic [15:0] hour_out;
    logic [21:0] ms_out;
    logic [4:0]  queue_count;
    logic        last;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    op_t         op;
    logic [15:0] hour;
    logic [21:0] ms;
    logic [41:0] limit;
    logic [7:0]  code;
    logic [15:0] proxy;
    logic [15:0] owner;
    logic [31:0] handle;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_REM, F_MUL, F_EMIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_PUSH, B_POP, B_DEL, B_OUT
  } back_state_t;
endpackage

>>> rtl/core/taq_front.sv
// Front end: accepts items, normalizes push times, builds pop limits.
// Depends on taq_pkg.
`timescale 1ns / 1ps
module taq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  taq_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output taq_pkg::cmd_t     cmd
);
  import taq_pkg::*;

  front_state_t state, state_next;
  in_item_t     item;
  logic [31:0]  rem;
  logic [15:0]  quot;
  logic [50:0]  qprod;
  logic [41:0]  prod;
  logic         long_ms;

  assign in_ready = (state == F_IDLE);
  assign cmd_valid = (state == F_EMIT);
  assign long_ms = (in_item.sec_ms > {10'd0, MS_PER_HOUR});

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) begin
        if (in_item.op == OP_PUSH && long_ms) state_next = F_DIV;
        else if (in_item.op == OP_POP_DUE) state_next = F_MUL;
        else if (in_item.op <= OP_CLEAR) state_next = F_EMIT;
      end
      F_DIV: state_next = F_REM;
      F_REM: state_next = F_EMIT;
      F_MUL: state_next = F_EMIT;
      F_EMIT: if (cmd_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  // hours = (sec_ms >> 7) / 28125 by reciprocal multiply, then remainder
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      item <= in_item;
      rem  <= in_item.sec_ms;
      quot <= 16'd0;
    end else if (state == F_DIV) begin
      qprod <= {26'd0, item.sec_ms[31:7]} * {25'd0, HOUR_RECIP};
    end else if (state == F_REM) begin
      quot <= {5'd0, qprod[50:40]};
      rem  <= item.sec_ms - ({21'd0, qprod[50:40]} * {10'd0, MS_PER_HOUR});
    end else if (state == F_MUL) begin
      prod <= {26'd0, item.hour} * {20'd0, MS_PER_HOUR} + {10'd0, item.sec_ms};
    end
  end

  logic [16:0] hsum;
  assign hsum = {1'b0, item.hour} + {1'b0, quot};

  always_comb begin
    cmd.op     = op_t'(item.op);
    cmd.hour   = hsum[16] ? 16'hFFFF : hsum[15:0];
    cmd.ms     = rem[21:0];
    cmd.limit  = prod;
    cmd.code   = item.action_code;
    cmd.proxy  = item.proxy;
    cmd.owner  = item.owner_id;
    cmd.handle = item.handle;
  end
endmodule

>>> rtl/core/taq_cmd_fifo.sv
// Two-entry queue between front and back.
// Depends on taq_pkg.
`timescale 1ns / 1ps
module taq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  taq_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output taq_pkg::cmd_t rd_data
);
  import taq_pkg::*;

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

>>> rtl/core/taq_back.sv
// Back end: sorted slot chain, insert, pop, delete, clear; result register.
// Depends on taq_pkg.
`timescale 1ns / 1ps
module taq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  taq_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output taq_pkg::out_item_t out_item
);
  import taq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0] hour;
    logic [21:0] ms;
    logic [41:0] key;
    logic [7:0]  code;
    logic [15:0] proxy;
    logic [15:0] owner;
    logic [31:0] handle;
  } slot_t;

  slot_t       slots [QUEUE_DEPTH];
  logic [CW-1:0] occ;
  logic [31:0] serial;
  back_state_t state, state_next;
  cmd_t        c;
  logic [41:0] key_new, lim;
  logic [4:0]  npop;
  out_item_t   res, res_next;
  logic        res_v;

  assign cmd_ready = (state == B_IDLE);
  assign out_valid = res_v;
  assign out_item  = res;

  // per-cell compares
  logic [QUEUE_DEPTH-1:0] ge, hit, live;
  logic [QUEUE_DEPTH-1:0] hit_first, ge_first;
  logic [IW-1:0] hit_idx;
  logic          any_hit;
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      live[i] = (CW'(i) < occ);
      ge[i]   = live[i] && (key_new <= slots[i].key);
      hit[i]  = live[i] && (slots[i].handle == c.handle);
    end
    hit_first = hit & ~(hit - 1'b1);
    ge_first = ge & ~(ge - 1'b1);
    any_hit = |hit;
    hit_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (hit_first[i]) hit_idx = IW'(i);
  end

  logic res_free, res_load;
  assign res_free = !res_v || out_ready;
  assign res_load = res_free && (state != B_IDLE);
  logic head_due;
  assign head_due = (occ != '0) && (slots[0].key <= lim) && (npop != 5'(MAX_RESULTS));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (cmd_valid) begin
        unique case (cmd.op)
          OP_PUSH:     state_next = B_PUSH;
          OP_DELETE:   state_next = B_DEL;
          OP_POP_DUE, OP_POP_NEAR: state_next = B_POP;
          default:     state_next = B_OUT;
        endcase
      end
      B_PUSH, B_DEL, B_OUT: if (res_free) state_next = B_IDLE;
      B_POP: if (res_free) begin
        if (!head_due || (occ == CW'(1)) || (npop == 5'(MAX_RESULTS - 1)) ||
            (slots[1].key > lim)) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && cmd_valid) begin
      c       <= cmd;
      key_new <= {26'd0, cmd.hour} * {20'd0, MS_PER_HOUR} + {20'd0, cmd.ms};
      lim     <= (cmd.op == OP_POP_DUE) ? cmd.limit : slots[0].key;
      npop    <= 5'd0;
    end else if (state == B_POP && res_free) begin
      npop <= npop + 5'd1;
    end
  end

  // result of the current command
  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    case (state)
      B_PUSH: begin
        if (occ == CW'(QUEUE_DEPTH)) begin
          res_next.status = ST_FULL;
          res_next.queue_count = 5'(occ);
        end else begin
          res_next.status = ST_PUSHED;
          res_next.handle_out = serial + 32'd1;
          res_next.queue_count = 5'(occ + CW'(1));
        end
      end
      B_POP: begin
        if (head_due) begin
          res_next.status = ST_POPPED;
          res_next.handle_out = slots[0].handle;
          res_next.code_out = slots[0].code;
          res_next.proxy_out = slots[0].proxy;
          res_next.owner_out = slots[0].owner;
          res_next.hour_out = slots[0].hour;
          res_next.ms_out = slots[0].ms;
          res_next.queue_count = 5'(occ - CW'(1));
          res_next.last = (state_next == B_IDLE);
        end else begin
          res_next.status = ST_NONE;
          res_next.queue_count = 5'(occ);
        end
      end
      B_DEL: begin
        if (any_hit) begin
          res_next.status = ST_DELETED;
          res_next.handle_out = slots[hit_idx].handle;
          res_next.code_out = slots[hit_idx].code;
          res_next.proxy_out = slots[hit_idx].proxy;
          res_next.owner_out = slots[hit_idx].owner;
          res_next.hour_out = slots[hit_idx].hour;
          res_next.ms_out = slots[hit_idx].ms;
          res_next.queue_count = 5'(occ - CW'(1));
        end else begin
          res_next.status = ST_NOT_FOUND;
          res_next.queue_count = 5'(occ);
        end
      end
      B_OUT: res_next.status = ST_CLEARED;
      default: ;
    endcase
  end

  // slot chain
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0; serial <= '0; res_v <= 1'b0;
    end else begin
      res_v <= res_load || (res_v && !out_ready);
      if (res_load) begin
        unique case (state)
          B_PUSH: begin
            if (occ != CW'(QUEUE_DEPTH)) begin
              for (int i = QUEUE_DEPTH - 1; i > 0; i--)
                if (ge[i-1]) slots[i] <= slots[i-1];
              for (int i = 0; i < QUEUE_DEPTH; i++)
                if (ge_first[i] || (ge == '0 && CW'(i) == occ))
                  slots[i] <= '{hour: c.hour, ms: c.ms, key: key_new, code: c.code,
                                proxy: c.proxy, owner: c.owner,
                                handle: serial + 32'd1};
              serial <= serial + 32'd1;
              occ <= occ + CW'(1);
            end
          end
          B_POP: begin
            if (head_due) begin
              for (int i = 0; i < QUEUE_DEPTH - 1; i++) slots[i] <= slots[i+1];
              occ <= occ - CW'(1);
            end
          end
          B_DEL: begin
            if (any_hit) begin
              for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                if (IW'(i) >= hit_idx) slots[i] <= slots[i+1];
              occ <= occ - CW'(1);
            end
          end
          B_OUT: occ <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
  end
endmodule

>>> rtl/core/timed_action_queue.sv
// Top level of the timed action queue: front, command queue and back.
// Depends on taq_pkg, taq_front, taq_cmd_fifo, taq_back.
// The front holds one item at a time and takes the next once its command
// is handed on; a push whose ms exceed one hour first passes a reciprocal
// multiply and a remainder step, and a pop-due a limit multiply. Results
// come from the back's result register. The back takes a new command only
// while idle; while popping a run of due entries from the sorted slot chain
// it emits one result per cycle as long as results are taken. Up to two
// commands queue between front and back. No clearing pass after reset.
`timescale 1ns / 1ps
module timed_action_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  taq_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output taq_pkg::out_item_t out_item
);
  import taq_pkg::*;

  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready, in_ready, out_valid;

  assign full  = !in_ready;
  assign empty = !out_valid;

  taq_front u_front (
    .clk, .rst, .in_valid(push), .in_ready, .in_item,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  taq_cmd_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
  );

  taq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .out_valid, .out_ready(pop), .out_item
  );
endmodule

>>> rtl/core/taq_checker.sv
// Port-level checks of the timed action queue, bound to the top level.
// Depends on taq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module taq_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input taq_pkg::out_item_t out_item
);
  import taq_pkg::*;

  logic push_res, clr_res;
  assign push_res = !empty && (out_item.status == ST_PUSHED || out_item.status == ST_FULL);
  assign clr_res = !empty && (out_item.status == ST_CLEARED);

  `CHK_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(out_item), "result moved")
  `CHK_IMPL(a_cnt, clk, rst, !empty, out_item.queue_count <= 5'd16, "count out of range")
  `CHK_IMPL(a_pushlast, clk, rst, push_res, out_item.last, "push result not last")
  `CHK_IMPL(a_clr, clk, rst, clr_res, out_item.queue_count == 5'd0, "clear left entries")
endmodule

bind timed_action_queue taq_checker u_checker (
  .clk, .rst, .empty, .pop, .out_item
);

>>> bench/timed_action_queue_tb.sv
// Self-checking bench for timed_action_queue: directed table, then random items
// checked against a sorted-slot model of the queue. Depends on taq_pkg and the RTL.
`timescale 1ns / 1ps
module timed_action_queue_tb;
  import taq_pkg::*;

  localparam int DEPTH = 16;
  localparam longint unsigned HOUR_MS = 64'd3600000;
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_MID = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [15:0] hr;
    logic [21:0] ms;
    logic [7:0]  code;
    logic [15:0] prx;
    logic [15:0] own;
    logic [31:0] hdl;
  } slot_t;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_item_t in_item = '0;
  out_item_t out_item;

  slot_t slots[$];
  logic [31:0] serial = '0;
  out_item_t fresh[$];
  out_item_t pending[$];
  int errors = 0;
  bit hold_req = 0;
  bit no_idle = 0;
  int idle_cnt = 0;

  timed_action_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned key_of(slot_t s);
    return longint'(s.hr) * HOUR_MS + s.ms;
  endfunction

  function automatic out_item_t res_of(logic [2:0] st, logic [31:0] h, logic [4:0] cnt);
    out_item_t r;
    r = '0;
    r.status = st;
    r.handle_out = h;
    r.queue_count = cnt;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void emit_slot(logic [2:0] st, slot_t s);
    out_item_t r;
    r = '0;
    r.status = st;
    r.handle_out = s.hdl;
    r.code_out = s.code;
    r.proxy_out = s.prx;
    r.owner_out = s.own;
    r.hour_out = s.hr;
    r.ms_out = s.ms;
    r.queue_count = 5'(slots.size());
    fresh.insert(fresh.size(), r);
  endfunction

  function automatic void drain_upto(longint unsigned lim);
    int n;
    slot_t s;
    n = 0;
    while (slots.size() > 0 && n < MAX_RESULTS && key_of(slots[0]) <= lim) begin
      s = slots.pop_front();
      emit_slot(ST_POPPED, s);
      n++;
    end
    if (n == 0) fresh.insert(fresh.size(), res_of(ST_NONE, '0, 5'(slots.size())));
  endfunction

  // expected results of one accepted item, left in fresh
  function automatic void forecast(in_item_t it);
    slot_t s;
    longint unsigned hr, k;
    int pos;
    bit hit;
    fresh.delete();
    case (it.op)
      OP_PUSH: begin
        if (slots.size() >= DEPTH) begin
          fresh.insert(fresh.size(), res_of(ST_FULL, '0, 5'(slots.size())));
        end else begin
          hr = 64'(it.hour);
          s.ms = it.sec_ms[21:0];
          if (it.sec_ms > HOUR_MS) begin
            hr = hr + it.sec_ms / HOUR_MS;
            s.ms = 22'(it.sec_ms % HOUR_MS);
          end
          if (hr > 65535) hr = 65535;
          s.hr = 16'(hr);
          s.code = it.action_code;
          s.prx = it.proxy;
          s.own = it.owner_id;
          serial = serial + 32'd1;
          s.hdl = serial;
          k = key_of(s);
          pos = slots.size();
          for (int i = 0; i < slots.size(); i++) begin
            if (k <= key_of(slots[i])) begin
              pos = i;
              break;
            end
          end
          slots.insert(pos, s);
          fresh.insert(fresh.size(), res_of(ST_PUSHED, serial, 5'(slots.size())));
        end
      end
      OP_POP_DUE: drain_upto(longint'(it.hour) * HOUR_MS + it.sec_ms);
      OP_POP_NEAR: begin
        if (slots.size() == 0) fresh.insert(fresh.size(), res_of(ST_NONE, '0, 5'd0));
        else drain_upto(key_of(slots[0]));
      end
      OP_DELETE: begin
        hit = 0;
        for (int i = 0; i < slots.size(); i++) begin
          if (slots[i].hdl == it.handle) begin
            s = slots[i];
            slots.delete(i);
            emit_slot(ST_DELETED, s);
            hit = 1;
            break;
          end
        end
        if (!hit) fresh.insert(fresh.size(), res_of(ST_NOT_FOUND, '0, 5'(slots.size())));
      end
      OP_CLEAR: begin
        slots.delete();
        fresh.insert(fresh.size(), res_of(ST_CLEARED, '0, 5'd0));
      end
      default: ;
    endcase
    if (fresh.size() > 0) begin
      foreach (fresh[i]) fresh[i].last = 1'b0;
      fresh[fresh.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic [15:0] hour, logic [31:0] sec,
                                  logic [7:0] code, logic [15:0] prx, logic [15:0] own,
                                  logic [31:0] hdl);
    in_item_t it;
    it.op = op;
    it.hour = hour;
    it.sec_ms = sec;
    it.action_code = code;
    it.proxy = prx;
    it.owner_id = own;
    it.handle = hdl;
    return it;
  endfunction

  function automatic row_t row(in_item_t it, bit typed, out_item_t res);
    row_t rw;
    rw.it = it;
    rw.typed = typed;
    rw.res = res;
    return rw;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t rand_item(int mode);
    in_item_t it;
    int r;
    it = in_item_t'(123'({$urandom, $urandom, $urandom, $urandom}));
    r = (mode == 1) ? 0 : $urandom_range(0, 99);
    if (r < 45) begin
      it.op = OP_PUSH;
      it.hour = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      if (r < 4) it.sec_ms = $urandom_range(0, 3) * 900000;
      else if (r < 7) it.sec_ms = $urandom_range(0, 3600000);
      else if (r < 8) it.sec_ms = 32'd3600000;
      else it.sec_ms = $urandom;
    end else if (r < 60) begin
      it.op = OP_POP_DUE;
      if ($urandom_range(0, 9) != 0) begin
        it.hour = 16'($urandom_range(0, 3));
        it.sec_ms = $urandom_range(0, 3600000);
      end
    end else if (r < 72) begin
      it.op = OP_POP_NEAR;
    end else if (r < 85) begin
      it.op = OP_DELETE;
      if ($urandom_range(0, 9) < 6) it.handle = serial - $urandom_range(0, 20);
    end else if (r < 88) begin
      it.op = OP_CLEAR;
    end else if (r < 91) begin
      it.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    end
    return it;
  endfunction

  task automatic send(row_t rw);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= rw.it;
    do @(posedge clk); while (full);
    forecast(rw.it);
    if (rw.typed) pending.insert(pending.size(), rw.res);
    else foreach (fresh[i]) pending.insert(pending.size(), fresh[i]);
  endtask

  task automatic send_rand(int mode, inout int cnt);
    row_t rw;
    rw.it = rand_item(mode);
    rw.typed = 0;
    rw.res = '0;
    send(rw);
    if (rw.it.op <= OP_CLEAR) cnt++;
  endtask

  task automatic cmp(string f, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t %s expected %0h actual %0h", $time, f, e, a);
      errors++;
    end
  endtask

  // result side
  initial begin
    int stall;
    out_item_t e;
    stall = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending.size() == 0) begin
          $display("%0t item with nothing expected: %p", $time, out_item);
          errors++;
        end else begin
          e = pending.pop_front();
          cmp("status", e.status, out_item.status);
          cmp("handle_out", e.handle_out, out_item.handle_out);
          cmp("code_out", e.code_out, out_item.code_out);
          cmp("proxy_out", e.proxy_out, out_item.proxy_out);
          cmp("owner_out", e.owner_out, out_item.owner_out);
          cmp("hour_out", e.hour_out, out_item.hour_out);
          cmp("ms_out", e.ms_out, out_item.ms_out);
          cmp("queue_count", e.queue_count, out_item.queue_count);
          cmp("last", e.last, out_item.last);
        end
      end
      if (hold_req) begin
        hold_req = 0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        pop <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        pop <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IDLE_LIMIT) begin
      $display("timed_action_queue: mismatch");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    int cnt;
    int wait_cyc;
    bit paused;
    cnt = 0;
    paused = 0;
    dir.insert(dir.size(), row(mk(OP_POP_NEAR, '0, '0, '0, '0, '0, '0), 1'b1,
                               res_of(ST_NONE, '0, '0)));
    dir.insert(dir.size(), row(mk(OP_POP_DUE, 16'hffff, 32'hffffffff, '0, '0, '0, '0),
                               1'b1, res_of(ST_NONE, '0, '0)));
    dir.insert(dir.size(), row(mk(OP_DELETE, '0, '0, '0, '0, '0, '0), 1'b1,
                               res_of(ST_NOT_FOUND, '0, '0)));
    dir.insert(dir.size(), row(mk(OP_PUSH, '0, '0, 8'hff, 16'hffff, 16'hffff, '0), 1'b1,
                               res_of(ST_PUSHED, 32'd1, 5'd1)));
    dir.insert(dir.size(), row(mk(OP_PUSH, 16'hffff, 32'hffffffff, 8'h00, '0, '0,
                                  32'hffffffff), 1'b1, res_of(ST_PUSHED, 32'd2, 5'd2)));
    dir.insert(dir.size(), row(mk(OP_PUSH, 16'd5, 32'd3600000, 8'h11, 16'h1234, 16'h5678,
                                  '0), 1'b1, res_of(ST_PUSHED, 32'd3, 5'd3)));
    dir.insert(dir.size(), row(mk(OP_PUSH, 16'd4, 32'd3600001, 8'h22, 16'h0001, 16'h8000,
                                  '0), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_PUSH, 16'd5, 32'd3600000, 8'h33, 16'h8000, 16'h0001,
                                  '0), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_PUSH, 16'hfffe, 32'd7200000, 8'h44, 16'h00ff,
                                  16'hff00, '0), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_POP_NEAR, '0, '0, '0, '0, '0, '0), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_POP_DUE, 16'd6, '0, '0, '0, '0, '0), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_DELETE, '0, '0, '0, '0, '0, 32'd2), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_DELETE, '0, '0, '0, '0, '0, 32'd2), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_UNDEF_LO, 16'd1, 32'd1, 8'd1, 16'd1, 16'd1, 32'd1),
                               1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_UNDEF_MID, '0, '0, '0, '0, '0, '0), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_UNDEF_HI, 16'hffff, 32'hffffffff, 8'hff, 16'hffff,
                                  16'hffff, 32'hffffffff), 1'b0, '0));
    dir.insert(dir.size(), row(mk(OP_CLEAR, '0, '0, '0, '0, '0, '0), 1'b1,
                               res_of(ST_CLEARED, '0, '0)));
    dir.insert(dir.size(), row(mk(OP_POP_DUE, '0, '0, '0, '0, '0, '0), 1'b1,
                               res_of(ST_NONE, '0, '0)));
    dir.insert(dir.size(), row(mk(OP_DELETE, '0, '0, '0, '0, '0, 32'hffffffff), 1'b1,
                               res_of(ST_NOT_FOUND, '0, '0)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (dir[i]) send(dir[i]);

    // stall the result side while items keep coming
    hold_req = 1;
    no_idle = 1;
    repeat (30) send_rand(0, cnt);
    no_idle = 0;

    while (cnt < 320) begin
      if (!paused && cnt > 150) begin
        push <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        paused = 1;
      end
      case ($urandom_range(0, 5))
        0: begin
          repeat (DEPTH + 2) send_rand(1, cnt);
          send(row(mk(OP_POP_DUE, 16'hffff, 32'hffffffff, '0, '0, '0, '0), 1'b0, '0));
          cnt++;
        end
        1: begin
          no_idle = 1;
          repeat (15) send_rand(0, cnt);
          no_idle = 0;
        end
        default: repeat (20) send_rand(0, cnt);
      endcase
    end
    push <= 1'b0;

    wait_cyc = 0;
    while (pending.size() != 0 && wait_cyc < 20000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (30) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("timed_action_queue: match");
    end else begin
      $display("timed_action_queue: mismatch");
    end
    $finish;
  end
endmodule

>>> timed_action_queue.f
+incdir+rtl/core
rtl/core/taq_pkg.sv
rtl/core/taq_front.sv
rtl/core/taq_cmd_fifo.sv
rtl/core/taq_back.sv
rtl/core/timed_action_queue.sv
rtl/core/taq_checker.sv
bench/timed_action_queue_tb.sv
